FILE: hw/rtl/ultrasonic_range_frame_filter_macros.svh
// ============================================================================
// Ultrasonic range frame filter assertion macros
// Shared concurrent assertion forms for the checker.
// ============================================================================
`ifndef ULTRASONIC_RANGE_FRAME_FILTER_MACROS_SVH
`define ULTRASONIC_RANGE_FRAME_FILTER_MACROS_SVH

// same-cycle implication, off during reset
`define URFF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urff assertion failed");

// next-cycle implication, off during reset
`define URFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urff assertion failed");

`endif

FILE: hw/rtl/urff_pkg.sv
// ============================================================================
// Ultrasonic range frame filter package
// Types, codes and constants shared by the filter modules.
// ============================================================================
package urff_pkg;

    localparam int IDX_W   = 2;
    localparam int CDATA_W = 13;
    localparam int TICK_W  = 8;
    localparam int TMO_W   = 10;
    localparam int LIMIT_W = 13;
    localparam int LIM_MM_W = 17;
    localparam int COUNT_W = 11;
    localparam int BYTE_W  = 8;
    localparam int RAW_W   = 16;
    localparam int STAT_W  = 2;
    localparam int CM_W    = 13;
    localparam int FILT_W  = 20;
    localparam int DELTA_W = 21;
    localparam int OUT_W   = 56;

    localparam logic [IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
    localparam logic [IDX_W-1:0] REG_TIMEOUT     = 2'd1;
    localparam logic [IDX_W-1:0] REG_RANGE_LIMIT = 2'd2;

    localparam logic [TICK_W-1:0]   TICK_RESET  = 8'd50;
    localparam logic [TMO_W-1:0]    TMO_RESET   = 10'd200;
    localparam logic [LIM_MM_W-1:0] LIMIT_MM_RESET = 17'd5000;

    localparam logic [STAT_W-1:0] ST_NONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_VALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic [FILT_W-1:0] FILT_MAX = 20'hFFFFF;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0]   tick_period;
        logic [TMO_W-1:0]    timeout;
        logic [LIM_MM_W-1:0] limit_mm;
    } cfg_t;

    typedef struct packed {
        logic [DELTA_W-1:0] height_delta;
        logic [FILT_W-1:0]  filtered_height;
        logic [CM_W-1:0]    height_cm;
        logic [STAT_W-1:0]  status;
    } result_t;

endpackage

FILE: hw/rtl/urff_cfg.sv
// ============================================================================
// Ultrasonic range frame filter configuration registers
// Holds tick period, timeout and the range limit scaled to millimetres.
// ============================================================================
module urff_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [urff_pkg::IDX_W-1:0]     cfg_index,
    input  logic [urff_pkg::CDATA_W-1:0]   cfg_data,
    output urff_pkg::cfg_t                 cfg
);
    import urff_pkg::*;

    logic [TICK_W-1:0]   tick_reg;
    logic [TMO_W-1:0]    tmo_reg;
    logic [LIM_MM_W-1:0] limit_mm_reg;
    logic [LIM_MM_W-1:0] limit_mm_next;

    // scale centimetres to millimetres: v * 10 = (v << 3) + (v << 1)
    assign limit_mm_next = (LIM_MM_W'(cfg_data) << 3) + (LIM_MM_W'(cfg_data) << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= TICK_RESET;
            tmo_reg      <= TMO_RESET;
            limit_mm_reg <= LIMIT_MM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TICK_PERIOD: tick_reg     <= cfg_data[TICK_W-1:0];
                REG_TIMEOUT:     tmo_reg      <= cfg_data[TMO_W-1:0];
                REG_RANGE_LIMIT: limit_mm_reg <= limit_mm_next;
                default:         tick_reg     <= tick_reg;
            endcase
        end
    end

    assign cfg.tick_period = tick_reg;
    assign cfg.timeout     = tmo_reg;
    assign cfg.limit_mm    = limit_mm_reg;

endmodule

FILE: hw/rtl/urff_core.sv
// ============================================================================
// Ultrasonic range frame filter core
// Frame assembly, timeout, range check and half-weight filter state.
// ============================================================================
module urff_core
#(
    parameter int FRACTION_BITS = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          mode,
    input  logic [urff_pkg::BYTE_W-1:0]   data_byte,
    input  urff_pkg::cfg_t                cfg,
    output urff_pkg::result_t             result
);
    import urff_pkg::*;

    localparam int SHIFT_W = RAW_W + FRACTION_BITS;
    localparam int SUM_W   = ((SHIFT_W > FILT_W) ? SHIFT_W : FILT_W) + 1;
    localparam int HALF_W  = SUM_W - 1;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   high_reg, high_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [CM_W-1:0]     cm_reg, cm_next;
    logic [FILT_W-1:0]   filt_reg, filt_next;
    logic [FILT_W-1:0]   prev_reg, prev_next;

    logic [RAW_W-1:0]    raw;
    logic [32:0]         prod;
    logic [CM_W-1:0]     quot;
    logic                in_range;
    logic [SUM_W-1:0]    sum;
    logic [HALF_W-1:0]   half;
    logic [FILT_W-1:0]   filt_sat;

    assign raw      = {high_reg, data_byte};
    assign prod     = 33'(raw) * 33'(DIV10_MUL);
    assign quot     = prod[DIV10_SHIFT +: CM_W];
    assign in_range = (LIM_MM_W'(raw) < cfg.limit_mm);
    assign sum      = (SUM_W'(raw) << FRACTION_BITS) + SUM_W'(prev_reg);
    assign half     = sum[SUM_W-1:1];
    assign filt_sat = (half > HALF_W'(FILT_MAX)) ? FILT_MAX : half[FILT_W-1:0];

    always_comb
    begin
        phase_next  = phase_reg;
        high_next   = high_reg;
        count_next  = count_reg;
        status_next = status_reg;
        cm_next     = cm_reg;
        filt_next   = filt_reg;
        prev_next   = prev_reg;
        if (!mode)
        begin
            phase_next = PH_HIGH;
            if (count_reg < COUNT_W'(cfg.timeout))
                count_next = count_reg + COUNT_W'(cfg.tick_period);
            else
                status_next = ST_NONE;
        end
        else
        begin
            case (phase_reg)
                PH_HIGH:
                begin
                    high_next  = data_byte;
                    phase_next = PH_LOW;
                end
                PH_LOW:
                begin
                    cm_next = quot;
                    if (in_range)
                    begin
                        filt_next   = filt_sat;
                        status_next = ST_VALID;
                    end
                    else
                        status_next = ST_RANGE;
                    phase_next = PH_IDLE;
                end
                default: phase_next = PH_IDLE;
            endcase
            count_next = '0;
            prev_next  = filt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            high_reg   <= '0;
            count_reg  <= '0;
            status_reg <= ST_NONE;
            cm_reg     <= '0;
            filt_reg   <= '0;
            prev_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            high_reg   <= high_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            cm_reg     <= cm_next;
            filt_reg   <= filt_next;
            prev_reg   <= prev_next;
        end
    end

    assign result.status          = status_next;
    assign result.height_cm       = cm_next;
    assign result.filtered_height = filt_next;
    assign result.height_delta    = {1'b0, filt_next} - {1'b0, prev_reg};

endmodule

FILE: hw/rtl/ultrasonic_range_frame_filter.sv
// ============================================================================
// Ultrasonic range frame filter
// Tick-driven range frame assembly with timeout and half-weight filtering.
// ============================================================================
// Input stream: one word per event. s_axis_tuser is the kind (0 tick,
// 1 sensor byte), s_axis_tdata the received byte (ignored on a tick).
// Output stream: exactly one word per input word, in order. m_axis_tuser
// is the command pulse (1 for a tick), m_axis_tdata the status, height in
// centimetres, filtered height in 1/(10*2^FRACTION_BITS) cm and its delta.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 tick
// period, 1 timeout, 2 range limit); write only while idle.
// An accepted word waits in the input register until its result is registered.
// Throughput: one word per cycle while results are taken; the input register
// and the result register form a two-entry pipeline, so the input can take
// one word while a result waits. Reset clears the pipeline and all frame,
// timeout and filter state and loads the register defaults. When the
// receiver stalls, the result holds and one more word is taken into the input
// register, then s_axis_tready drops until the result is taken.
// ============================================================================
module ultrasonic_range_frame_filter
#(
    parameter int FRACTION_BITS = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    input  logic                          s_axis_tuser,  // [0] mode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] status, [14:2] height_cm, [34:15] filtered_height,
    // [55:35] height_delta
    output logic [urff_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tuser,  // [0] command_pulse
    input  logic                          cfg_we,
    input  logic [urff_pkg::IDX_W-1:0]    cfg_index,
    input  logic [urff_pkg::CDATA_W-1:0]  cfg_data
);
    import urff_pkg::*;

    cfg_t               cfg;
    result_t            result;
    logic               in_valid_reg;
    logic               in_mode_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               out_valid_reg;
    logic               out_pulse_reg;
    result_t            out_data_reg;
    logic               advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    urff_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    urff_core #(.FRACTION_BITS(FRACTION_BITS)) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .mode      (in_mode_reg),
        .data_byte (in_byte_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_mode_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_pulse_reg <= !in_mode_reg;
            out_data_reg  <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_pulse_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: hw/rtl/urff_checker.sv
// ============================================================================
// Ultrasonic range frame filter checker
// Port-level checks on the filter, bound to the top level.
// ============================================================================
`include "ultrasonic_range_frame_filter_macros.svh"

module urff_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [55:0]  m_axis_tdata,
    input  logic         m_axis_tuser
);

    `URFF_ASSERT_NEXT(a_hold_stalled, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `URFF_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready)

    `URFF_ASSERT_IMPLY(a_tick_zero_delta, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[55:35] == 21'd0)

    `URFF_ASSERT_IMPLY(a_status_code, clk, rst_n, m_axis_tvalid,
        m_axis_tdata[1:0] != 2'd3)

endmodule

bind ultrasonic_range_frame_filter urff_checker u_urff_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: test/ultrasonic_range_frame_filter_checker.sv
// ============================================================================
// Ultrasonic range frame filter checker
// Watches the configuration port and both streams, keeps its own copy of the
// frame, timeout and filter state, and compares every output word field by
// field against the oldest predicted report.
// ============================================================================
package urff_tb_pkg;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

endpackage

module ultrasonic_range_frame_filter_checker
    import urff_pkg::*;
    import urff_tb_pkg::*;
#(
    parameter int FRACTION_BITS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
    input  logic                 s_axis_tuser,  // [0] mode
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [1:0] status, [14:2] height_cm, [34:15] filtered_height,
    // [55:35] height_delta
    input  logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 m_axis_tuser,  // [0] command_pulse
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CDATA_W-1:0]   cfg_data,
    output int                   error_count,
    output int                   owed_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               pulse;
        logic [STAT_W-1:0]  status;
        logic [CM_W-1:0]    height_cm;
        logic [FILT_W-1:0]  filtered;
        logic [DELTA_W-1:0] delta;
    } range_report_t;

    range_report_t      queued_reports[$];
    range_report_t      got_report;
    range_report_t      want_report;
    result_t            got_fields;
    int                 errors = 0;

    logic [TICK_W-1:0]  tick_ms;
    logic [TMO_W-1:0]   tmo_limit;
    logic [LIMIT_W-1:0] limit_cm;
    phase_t             frame_ph;
    logic [BYTE_W-1:0]  hi_byte;
    logic [COUNT_W-1:0] tmo_count;
    logic [STAT_W-1:0]  meas_status;
    logic [CM_W-1:0]    raw_cm;
    logic [FILT_W-1:0]  filt;
    logic [FILT_W-1:0]  prev_filt;

    function automatic range_report_t next_range_report(input logic kind,
                                                        input logic [7:0] b);
        range_report_t    rep;
        logic [RAW_W-1:0] raw_mm;
        logic [63:0]      sum;
        rep.pulse = (kind == KIND_TICK);
        if (kind == KIND_TICK)
        begin
            frame_ph = PH_HIGH;
            if (tmo_count < COUNT_W'(tmo_limit))
                tmo_count = tmo_count + COUNT_W'(tick_ms);
            else
                meas_status = ST_NONE;
        end
        else
        begin
            case (frame_ph)
                PH_HIGH:
                begin
                    hi_byte  = b;
                    frame_ph = PH_LOW;
                end
                PH_LOW:
                begin
                    raw_mm = {hi_byte, b};
                    raw_cm = CM_W'(raw_mm / 16'd10);
                    if (raw_cm < limit_cm)
                    begin
                        sum = ((64'(raw_mm) << FRACTION_BITS) + 64'(prev_filt)) >> 1;
                        filt = (sum > 64'(FILT_MAX)) ? FILT_MAX : sum[FILT_W-1:0];
                        meas_status = ST_VALID;
                    end
                    else
                        meas_status = ST_RANGE;
                    frame_ph = PH_IDLE;
                end
                default:
                    frame_ph = PH_IDLE;
            endcase
            tmo_count = '0;
        end
        rep.status    = meas_status;
        rep.height_cm = raw_cm;
        rep.filtered  = filt;
        rep.delta     = {1'b0, filt} - {1'b0, prev_filt};
        if (kind == KIND_BYTE)
            prev_filt = filt;
        return rep;
    endfunction

    task automatic note_error(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want_v,
                     got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ms     = TICK_RESET;
            tmo_limit   = TMO_RESET;
            limit_cm    = LIMIT_W'(500);
            frame_ph    = PH_IDLE;
            hi_byte     = '0;
            tmo_count   = '0;
            meas_status = ST_NONE;
            raw_cm      = '0;
            filt        = '0;
            prev_filt   = '0;
            queued_reports.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TICK_PERIOD: tick_ms   = cfg_data[TICK_W-1:0];
                    REG_TIMEOUT:     tmo_limit = cfg_data[TMO_W-1:0];
                    REG_RANGE_LIMIT: limit_cm  = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_fields           = result_t'(m_axis_tdata);
                got_report.pulse     = m_axis_tuser;
                got_report.status    = got_fields.status;
                got_report.height_cm = got_fields.height_cm;
                got_report.filtered  = got_fields.filtered_height;
                got_report.delta     = got_fields.height_delta;
                if (queued_reports.size() == 0)
                    note_error("unexpected word", '0, 32'(got_report.status));
                else
                begin
                    want_report = queued_reports.pop_front();
                    if (got_report.pulse !== want_report.pulse)
                        note_error("command_pulse", 32'(want_report.pulse),
                                   32'(got_report.pulse));
                    if (got_report.status !== want_report.status)
                        note_error("status", 32'(want_report.status),
                                   32'(got_report.status));
                    if (got_report.height_cm !== want_report.height_cm)
                        note_error("height_cm", 32'(want_report.height_cm),
                                   32'(got_report.height_cm));
                    if (got_report.filtered !== want_report.filtered)
                        note_error("filtered_height", 32'(want_report.filtered),
                                   32'(got_report.filtered));
                    if (got_report.delta !== want_report.delta)
                        note_error("height_delta", 32'(want_report.delta),
                                   32'(got_report.delta));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                queued_reports.push_back(next_range_report(s_axis_tuser, s_axis_tdata));
        end
        error_count <= errors;
        owed_count  <= queued_reports.size();
    end

endmodule

FILE: test/tb_ultrasonic_range_frame_filter.sv
// ============================================================================
// Ultrasonic range frame filter testbench
// Drives ticks and sensor bytes in random bursts against a stalling receiver,
// sweeps the tick period, timeout and range limit through their extremes,
// and takes the verdict from the checker's error and owed counts.
// ============================================================================
module tb_ultrasonic_range_frame_filter
    import urff_pkg::*;
    import urff_tb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRACTION_BITS = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_WORDS   = 235;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_data = '0;
    logic               s_user = KIND_TICK;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [OUT_W-1:0]   m_data;
    logic               m_user;
    logic               cfg_we = 1'b0;
    logic [IDX_W-1:0]   cfg_index = REG_TICK_PERIOD;
    logic [CDATA_W-1:0] cfg_data = '0;

    int                 error_count;
    int                 owed_count;
    int                 cycle_count = 0;
    int                 words_sent = 0;
    int                 burst_left = 0;
    int                 rx_mode = 0;
    int                 rx_left = 0;
    logic [LIMIT_W-1:0] cur_limit = LIMIT_W'(500);

    ultrasonic_range_frame_filter #(.FRACTION_BITS(FRACTION_BITS)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    ultrasonic_range_frame_filter_checker #(.FRACTION_BITS(FRACTION_BITS)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .owed_count    (owed_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ultrasonic_range_frame_filter regression: fail");
            $finish;
        end
    end

    // receiver stall patterns: always ready, coin flip, mostly ready, long stalls
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) == 1);
            2:       m_ready <= ($urandom_range(0, 7) != 0);
            default: m_ready <= (rx_left % 8 == 0);
        endcase
    end

    task automatic push_word(input logic kind, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= b;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        burst_left--;
        words_sent++;
    endtask

    task automatic drain_results();
        s_valid    <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (owed_count != 0) @(posedge clk);
    endtask

    task automatic load_config(input logic [CDATA_W-1:0] tick_val,
                               input logic [CDATA_W-1:0] tmo_val,
                               input logic [CDATA_W-1:0] lim_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TICK_PERIOD;
        cfg_data  <= tick_val;
        @(posedge clk);
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= tmo_val;
        @(posedge clk);
        cfg_index <= REG_RANGE_LIMIT;
        cfg_data  <= lim_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_limit = lim_val[LIMIT_W-1:0];
    endtask

    function automatic logic [15:0] pick_range_mm();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            v = $urandom_range(0, 65535);
        else if (sel < 7)
        begin
            v = int'(cur_limit) * 10 + int'($urandom_range(0, 24)) - 12;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
        end
        else if (sel == 7)
            v = $urandom_range(0, 9);
        else if (sel == 8)
            v = 65535 - int'($urandom_range(0, 9));
        else
            v = $urandom_range(0, 2559);
        return v[15:0];
    endfunction

    task automatic run_traffic(input int quota);
        int          stop_at;
        int          pick;
        logic [15:0] mm;
        stop_at = words_sent + quota;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
            begin
                mm = pick_range_mm();
                push_word(KIND_TICK, 8'($urandom_range(0, 255)));
                push_word(KIND_BYTE, mm[15:8]);
                push_word(KIND_BYTE, mm[7:0]);
            end
            else if (pick < 80)
                repeat ($urandom_range(2, 10))
                    push_word(KIND_TICK, 8'($urandom_range(0, 255)));
            else if (pick < 88)
            begin
                push_word(KIND_TICK, 8'($urandom_range(0, 255)));
                push_word(KIND_BYTE, 8'($urandom_range(0, 255)));
            end
            else if (pick < 97)
                repeat ($urandom_range(1, 3))
                    push_word(KIND_BYTE, 8'($urandom_range(0, 255)));
            else
                drain_results();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray bytes, zero range, max range, both sides of the default limit
        push_word(KIND_BYTE, 8'hFF);
        push_word(KIND_BYTE, 8'h00);
        push_word(KIND_TICK, 8'hFF);
        push_word(KIND_BYTE, 8'h00);
        push_word(KIND_BYTE, 8'h00);
        push_word(KIND_TICK, 8'h00);
        push_word(KIND_BYTE, 8'hFF);
        push_word(KIND_BYTE, 8'hFF);
        push_word(KIND_TICK, 8'hA5);
        push_word(KIND_BYTE, 8'h13);
        push_word(KIND_BYTE, 8'h87);
        push_word(KIND_TICK, 8'h5A);
        push_word(KIND_BYTE, 8'h13);
        push_word(KIND_BYTE, 8'h88);
        // restart mid-frame, then run ticks out to the timeout
        push_word(KIND_TICK, 8'h00);
        push_word(KIND_BYTE, 8'hAA);
        push_word(KIND_TICK, 8'hFF);
        push_word(KIND_BYTE, 8'h01);
        push_word(KIND_BYTE, 8'h02);
        repeat (5) push_word(KIND_TICK, 8'h55);
        drain_results();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: load_config(13'd1, 13'd1000, 13'd6554);
                1: load_config(13'd255, 13'd1, 13'd1);
                2: load_config(13'h1FFF, 13'h1FFF, 13'h1FFF);
                3: load_config(13'h100, 13'h400, 13'd0);
                4: load_config(13'd50, 13'd200, 13'd500);
                default:
                    if ($urandom_range(0, 3) == 0)
                        load_config(CDATA_W'($urandom_range(0, 8191)),
                                    CDATA_W'($urandom_range(0, 8191)),
                                    CDATA_W'($urandom_range(0, 8191)));
                    else
                        load_config(CDATA_W'($urandom_range(1, 255)),
                                    CDATA_W'($urandom_range(1, 1000)),
                                    CDATA_W'($urandom_range(1, 6554)));
            endcase
            run_traffic(PHASE_WORDS);
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0 && owed_count == 0)
            $display("ultrasonic_range_frame_filter regression: pass");
        else
            $display("ultrasonic_range_frame_filter regression: fail");
        $finish;
    end

endmodule
